// File: design/sul_pkg.sv
// Shared types and codes for the sorted unique list unit.
package sul_pkg;

  localparam logic [1:0] OP_ADD      = 2'd0;
  localparam logic [1:0] OP_REMOVE   = 2'd1;
  localparam logic [1:0] OP_INDEX_OF = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam int POS_W = 9;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [63:0] key_value;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [POS_W-1:0] position;
  } res_t;

  typedef struct packed {
    logic       load;
    logic       probe;
    logic       compare;
    logic       shift_init;
    logic       shift_wr;
    logic       commit;
    logic       finish;
    logic [1:0] fin_status;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       search_done;
    logic       found;
    logic       full;
    logic       shift_more;
  } dp_stat_t;

endpackage

// File: design/sul_datapath.sv
// Datapath: entry memory, search bounds, shift pointer, entry count and result register.
module sul_datapath #(
  parameter int CAPACITY = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  sul_pkg::req_t     request,
  input  sul_pkg::dp_cmd_t  cmd,
  output sul_pkg::dp_stat_t stat,
  output logic              done,
  output sul_pkg::res_t     result
);
  import sul_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic [63:0]        mem [CAPACITY];
  logic [63:0]        rdata;
  logic [1:0]         op;
  logic signed [63:0] key;
  logic [CW-1:0]      lo;
  logic [CW-1:0]      hi;
  logic [CW-1:0]      count;
  logic [CW-1:0]      ptr;
  logic               found;

  logic [CW-1:0] mid;
  logic [CW-1:0] ptr_dn;
  logic [CW-1:0] ptr_up;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [63:0]   wdata;
  logic          we;
  logic          is_add;
  logic          entry_less;

  assign mid        = lo + ((hi - lo) >> 1);
  assign ptr_dn     = ptr - CW'(1);
  assign ptr_up     = ptr + CW'(1);
  assign is_add     = (op == OP_ADD);
  assign entry_less = $signed(rdata) < key;

  always_comb begin
    if (cmd.probe) begin
      rd_addr = mid[AW-1:0];
    end else if (is_add) begin
      rd_addr = ptr_dn[AW-1:0];
    end else begin
      rd_addr = ptr_up[AW-1:0];
    end
  end

  assign we      = cmd.shift_wr || (cmd.commit && is_add);
  assign wr_addr = cmd.shift_wr ? ptr[AW-1:0] : lo[AW-1:0];
  assign wdata   = cmd.shift_wr ? rdata : key;

  always_ff @(posedge clk) begin
    rdata <= mem[rd_addr];
    if (we) begin
      mem[wr_addr] <= wdata;
    end
  end

  assign stat.op          = op;
  assign stat.search_done = !(lo < hi);
  assign stat.found       = found;
  assign stat.full        = (count == CW'(CAPACITY));
  assign stat.shift_more  = is_add ? (ptr > lo) : (ptr_up < count);

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op    <= request.opcode;
      key   <= request.key_value;
      lo    <= '0;
      hi    <= count;
      found <= 1'b0;
    end else if (cmd.compare) begin
      if (entry_less) begin
        lo <= mid + CW'(1);
      end else begin
        hi <= mid;
      end
      if (rdata == key) begin
        found <= 1'b1;
      end
    end
    if (cmd.shift_init) begin
      ptr <= is_add ? count : lo;
    end else if (cmd.shift_wr) begin
      ptr <= is_add ? ptr_dn : ptr_up;
    end
    if (cmd.finish) begin
      result.status   <= cmd.fin_status;
      result.position <= (cmd.fin_status == ST_OK) ? POS_W'(lo) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= cmd.finish;
      if (cmd.commit) begin
        count <= is_add ? count + CW'(1) : count - CW'(1);
      end
    end
  end

endmodule

// File: design/sul_controller.sv
// Controller: sequences search, shift and commit steps for one request.
module sul_controller (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  sul_pkg::dp_stat_t stat,
  output sul_pkg::dp_cmd_t  cmd,
  output logic              busy
);
  import sul_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_PROBE    = 7'b0000010,
    S_COMPARE  = 7'b0000100,
    S_DECIDE   = 7'b0001000,
    S_SHIFT_RD = 7'b0010000,
    S_SHIFT_WR = 7'b0100000,
    S_COMMIT   = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next     = state;
    cmd            = '0;
    cmd.fin_status = ST_MISS;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_PROBE;
        end
      end
      S_PROBE: begin
        if (stat.search_done) begin
          state_next = S_DECIDE;
        end else begin
          cmd.probe  = 1'b1;
          state_next = S_COMPARE;
        end
      end
      S_COMPARE: begin
        cmd.compare = 1'b1;
        state_next  = S_PROBE;
      end
      S_DECIDE: begin
        case (stat.op)
          OP_ADD: begin
            if (stat.found) begin
              cmd.finish = 1'b1;
              state_next = S_IDLE;
            end else if (stat.full) begin
              cmd.finish     = 1'b1;
              cmd.fin_status = ST_FULL;
              state_next     = S_IDLE;
            end else begin
              cmd.shift_init = 1'b1;
              state_next     = S_SHIFT_RD;
            end
          end
          OP_REMOVE: begin
            if (stat.found) begin
              cmd.shift_init = 1'b1;
              state_next     = S_SHIFT_RD;
            end else begin
              cmd.finish = 1'b1;
              state_next = S_IDLE;
            end
          end
          OP_INDEX_OF: begin
            cmd.finish     = 1'b1;
            cmd.fin_status = stat.found ? ST_OK : ST_MISS;
            state_next     = S_IDLE;
          end
          default: begin
            cmd.finish = 1'b1;
            state_next = S_IDLE;
          end
        endcase
      end
      S_SHIFT_RD: begin
        // read address follows the shift pointer; stop once the gap is reached
        state_next = stat.shift_more ? S_SHIFT_WR : S_COMMIT;
      end
      S_SHIFT_WR: begin
        cmd.shift_wr = 1'b1;
        state_next   = S_SHIFT_RD;
      end
      S_COMMIT: begin
        cmd.commit     = 1'b1;
        cmd.finish     = 1'b1;
        cmd.fin_status = ST_OK;
        state_next     = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: design/sorted_unique_list_unit.sv
// Top level of the sorted unique list unit: controller plus datapath.
// Keeps up to CAPACITY distinct signed 64-bit keys in ascending order.
// Request channel: drive request (opcode, key_value) with start high; the
// request is taken at a clock edge where start is high and busy is low.
// Opcodes: add, remove, index_of. Each request gives exactly one result.
// Result channel: done is high for one cycle with result (status, position)
// valid in that cycle; the receiver cannot stall, so capture it then.
// Search: the binary search makes each probe (probe, then compare) over the
// single registered read port of the entry memory, up to ceil(log2(n+1))
// probes for n stored keys. A lookup or failed request then goes through the
// decide state, and the result is registered. A successful add or remove
// moves each shifted entry through the same port, a read and then a write per
// entry (for add the entries from the position up, for remove those above it),
// then commits the entry count (and for add writes the key) with the result.
// The unit handles one request at a time; busy drops in the cycle the result
// is shown, so the next request may be taken then.
// Reset empties the store (entry count cleared); memory contents stay as
// they are and their values are never used until written.
module sorted_unique_list_unit #(
  parameter int CAPACITY = 256
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  sul_pkg::req_t  request,
  output logic           done,
  output sul_pkg::res_t  result
);
  import sul_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  sul_controller u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  sul_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .cmd     (cmd),
    .stat    (stat),
    .done    (done),
    .result  (result)
  );

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while a request is still in progress");

  a_fail_pos_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.status != ST_OK) |-> (result.position == '0))
    else $error("failed request reports a nonzero position");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.status == ST_OK || result.status == ST_MISS ||
              result.status == ST_FULL))
    else $error("result status carries an undefined code");

endmodule
